[rtl/core/wrpm_pkg.sv]
// Shared constants, command and status types for the windowed RMS and peak meter.
`timescale 1ns / 1ps
`default_nettype none
package wrpm_pkg;

	localparam int RING_DEPTH  = 4096;
	localparam int SAMPLE_BITS = 24;
	localparam int AW          = $clog2(RING_DEPTH);
	localparam int LEN_W       = AW + 1;
	localparam int SQ_BITS     = 2 * SAMPLE_BITS;
	localparam int ACC_BITS    = SQ_BITS + AW + 1;
	localparam int DIV_CW      = $clog2(ACC_BITS + 1);
	localparam int NW          = $clog2(ACC_BITS);
	localparam int FRAC_BITS   = 20;
	localparam int MANT_BITS   = 31;
	localparam int DB_W        = 15;

	localparam logic signed [26:0] K_AMP = 27'sd39456604;
	localparam logic signed [26:0] K_POW = 27'sd19728302;
	localparam int FULL_PEAK = SAMPLE_BITS - 1;
	localparam int FULL_RMS  = 2 * (SAMPLE_BITS - 1);
	localparam logic signed [DB_W-1:0] DB_FLOOR = -15'sd10000;

	localparam logic FUNC_PUSH = 1'b0;
	localparam logic FUNC_MEAS = 1'b1;

	localparam logic REG_LEN = 1'b0;
	localparam logic REG_OFF = 1'b1;

	typedef struct packed {
		logic push;
		logic load;
		logic walk;
		logic div_start;
		logic db_start;
		logic db_sel_rms;
		logic floor;
		logic cap_rms;
		logic cap_peak;
	} cmd_t;

	typedef struct packed {
		logic len_zero;
		logic acc_done;
		logic div_done;
		logic db_done;
	} status_t;

endpackage
`default_nettype wire

[rtl/core/wrpm_ctrl.sv]
// Sequencing state machine of the meter: push, window walk, divide and two dB conversions.
`timescale 1ns / 1ps
`default_nettype none
module wrpm_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire logic            func,
	input  wire wrpm_pkg::status_t st,
	output wrpm_pkg::cmd_t       cmd,
	output logic                 busy
);
	import wrpm_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_WALK = 3'd1;
	localparam logic [2:0] S_DIV  = 3'd2;
	localparam logic [2:0] S_DBR  = 3'd3;
	localparam logic [2:0] S_DBP  = 3'd4;

	logic [2:0] state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					if (func == FUNC_PUSH) begin
						cmd.push = 1'b1;
					end else if (st.len_zero) begin
						cmd.floor = 1'b1;
					end else begin
						cmd.load = 1'b1;
						state_d  = S_WALK;
					end
				end
			end
			S_WALK: begin
				cmd.walk = 1'b1;
				if (st.acc_done) begin
					cmd.div_start = 1'b1;
					state_d       = S_DIV;
				end
			end
			S_DIV: begin
				if (st.div_done) begin
					cmd.db_start   = 1'b1;
					cmd.db_sel_rms = 1'b1;
					state_d        = S_DBR;
				end
			end
			S_DBR: begin
				if (st.db_done) begin
					cmd.cap_rms  = 1'b1;
					cmd.db_start = 1'b1;
					state_d      = S_DBP;
				end
			end
			S_DBP: begin
				if (st.db_done) begin
					cmd.cap_peak = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);

	a_one_entry_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.push, cmd.load, cmd.floor}))
		else $error("more than one entry command at once");
	a_meas_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && func == FUNC_MEAS && !st.len_zero |=> busy)
		else $error("measurement did not start");
	a_peak_ends: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cap_peak |=> !busy)
		else $error("controller busy after final capture");
	a_push_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> !busy)
		else $error("push while busy");

endmodule
`default_nettype wire

[rtl/core/wrpm_div.sv]
// Restoring divider, one quotient bit per cycle, for the mean square.
`timescale 1ns / 1ps
`default_nettype none
module wrpm_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [wrpm_pkg::ACC_BITS-1:0] dividend,
	input  wire logic [wrpm_pkg::LEN_W-1:0]    divisor,
	output logic                               done,
	output logic [wrpm_pkg::ACC_BITS-1:0]      quot
);
	import wrpm_pkg::*;

	logic [ACC_BITS-1:0] quo_q;
	logic [LEN_W-1:0]    rem_q;
	logic [LEN_W-1:0]    dvs_q;
	logic [DIV_CW-1:0]   cnt_q;
	logic                run_q, done_q;
	logic [LEN_W:0]      rem_sh, rem_sub;
	logic                ge;

	assign rem_sh  = {rem_q, quo_q[ACC_BITS-1]};
	assign ge      = rem_sh >= {1'b0, dvs_q};
	assign rem_sub = rem_sh - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= DIV_CW'(ACC_BITS);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (run_q) begin
			quo_q <= {quo_q[ACC_BITS-2:0], ge};
			rem_q <= ge ? rem_sub[LEN_W-1:0] : rem_sh[LEN_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule
`default_nettype wire

[rtl/core/wrpm_db.sv]
// Level to hundredths of dB: normalise, log2 by repeated squaring, scale, round, clamp.
`timescale 1ns / 1ps
`default_nettype none
module wrpm_db (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	input  wire logic                             sel_rms,
	input  wire logic [wrpm_pkg::ACC_BITS-1:0]    mean,
	input  wire logic [wrpm_pkg::SAMPLE_BITS-1:0] peak,
	output logic                                  done,
	output logic signed [wrpm_pkg::DB_W-1:0]      res
);
	import wrpm_pkg::*;

	localparam logic [2:0] D_IDLE = 3'd0;
	localparam logic [2:0] D_NORM = 3'd1;
	localparam logic [2:0] D_MUL  = 3'd2;
	localparam logic [2:0] D_SQ   = 3'd3;
	localparam logic [2:0] D_SCL  = 3'd4;
	localparam logic [2:0] D_RND  = 3'd5;

	logic [2:0]              state_q;
	logic [ACC_BITS-1:0]     x_q, opnd;
	logic [NW-1:0]           n_q;
	logic [MANT_BITS-1:0]    y_q;
	logic [2*MANT_BITS-1:0]  p_q;
	logic [FRAC_BITS-1:0]    f_q;
	logic [4:0]              it_q;
	logic                    sel_q, done_q;
	logic signed [54:0]      prod_q, v;
	logic signed [27:0]      rel;
	logic signed [18:0]      r;
	logic [MANT_BITS:0]      t;
	logic signed [DB_W-1:0]  res_q;

	assign opnd = sel_rms ? mean : ACC_BITS'(peak);
	assign t    = p_q[2*MANT_BITS-1:MANT_BITS-1];
	assign rel  = $signed({2'b00, n_q, f_q})
		- (sel_q ? 28'sd0 + (28'(FULL_RMS) << FRAC_BITS) : (28'(FULL_PEAK) << FRAC_BITS));
	assign v    = prod_q + (55'sd1 <<< 35);
	assign r    = 19'(v >>> 36);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			done_q  <= 1'b0;
			it_q    <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				D_IDLE: begin
					if (start) begin
						state_q <= (opnd == '0) ? D_IDLE : D_NORM;
						done_q  <= (opnd == '0);
					end
				end
				D_NORM: begin
					if (x_q[ACC_BITS-1]) begin
						state_q <= D_MUL;
						it_q    <= '0;
					end
				end
				D_MUL: begin
					state_q <= D_SQ;
				end
				D_SQ: begin
					it_q    <= it_q + 1'b1;
					state_q <= (it_q == 5'(FRAC_BITS - 1)) ? D_SCL : D_MUL;
				end
				D_SCL: begin
					state_q <= D_RND;
				end
				D_RND: begin
					state_q <= D_IDLE;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= D_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			D_IDLE: begin
				if (start) begin
					x_q   <= opnd;
					n_q   <= NW'(ACC_BITS - 1);
					sel_q <= sel_rms;
					res_q <= DB_FLOOR;
				end
			end
			D_NORM: begin
				if (x_q[ACC_BITS-1]) begin
					y_q <= x_q[ACC_BITS-1 -: MANT_BITS];
					f_q <= '0;
				end else begin
					x_q <= {x_q[ACC_BITS-2:0], 1'b0};
					n_q <= n_q - 1'b1;
				end
			end
			D_MUL: begin
				p_q <= y_q * y_q;
			end
			D_SQ: begin
				if (t[MANT_BITS]) begin
					y_q <= t[MANT_BITS:1];
					f_q <= {f_q[FRAC_BITS-2:0], 1'b1};
				end else begin
					y_q <= t[MANT_BITS-1:0];
					f_q <= {f_q[FRAC_BITS-2:0], 1'b0};
				end
			end
			D_SCL: begin
				prod_q <= rel * (sel_q ? K_POW : K_AMP);
			end
			D_RND: begin
				if (r < -19'sd10000) begin
					res_q <= DB_FLOOR;
				end else if (r > 19'sd0) begin
					res_q <= '0;
				end else begin
					res_q <= r[DB_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	assign done = done_q;
	assign res  = res_q;

endmodule
`default_nettype wire

[rtl/core/wrpm_dp.sv]
// Datapath: configuration, sample ring, window placement, square and peak accumulation, outputs.
`timescale 1ns / 1ps
`default_nettype none
module wrpm_dp (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire wrpm_pkg::cmd_t                      cmd,
	input  wire logic signed [wrpm_pkg::SAMPLE_BITS-1:0] sample,
	input  wire logic                                cfg_we,
	input  wire logic                                cfg_idx,
	input  wire logic [wrpm_pkg::LEN_W-1:0]          cfg_data,
	input  wire logic signed [wrpm_pkg::DB_W-1:0]    db_res,
	output logic                                     len_zero,
	output logic                                     acc_done,
	output logic [wrpm_pkg::ACC_BITS-1:0]            sum,
	output logic [wrpm_pkg::LEN_W-1:0]               len,
	output logic [wrpm_pkg::SAMPLE_BITS-1:0]         peak,
	output logic                                     done,
	output logic signed [wrpm_pkg::DB_W-1:0]         rms_db,
	output logic signed [wrpm_pkg::DB_W-1:0]         peak_db
);
	import wrpm_pkg::*;

	logic [SAMPLE_BITS-1:0] ring_mem [0:RING_DEPTH-1];

	logic [LEN_W-1:0]       len_cfg_q, off_cfg_q;
	logic [AW-1:0]          wp_q, base_q, rd_addr, centre;
	logic [LEN_W-1:0]       fill_q, len_q, cnt_q, len_c, maxoff;
	logic signed [LEN_W:0]  off_in, maxo, off_c;
	logic [LEN_W:0]         start_c;
	logic                   issue;
	logic                   v_s1, v_s2, ok_s1;
	logic [SAMPLE_BITS-1:0] rd_s1, mag_s2, mag, peak_q;
	logic [SQ_BITS-1:0]     sq_s2;
	logic [ACC_BITS-1:0]    sum_q;
	logic                   done_q;
	logic signed [DB_W-1:0] rms_q, pk_q;

	// Window placement from the live configuration.
	assign len_c  = (len_cfg_q > LEN_W'(RING_DEPTH)) ? LEN_W'(RING_DEPTH) : len_cfg_q;
	assign maxoff = (LEN_W'(RING_DEPTH) - len_c) >> 1;
	assign off_in = $signed({off_cfg_q[LEN_W-1], off_cfg_q});
	assign maxo   = $signed({1'b0, maxoff});
	always_comb begin
		off_c = off_in;
		if (off_in > maxo) begin
			off_c = maxo;
		end else if (off_in < -maxo) begin
			off_c = -maxo;
		end
	end
	assign centre   = wp_q - AW'(RING_DEPTH / 2);
	assign start_c  = {2'b00, centre} - {1'b0, (len_c >> 1)} - $unsigned(off_c);
	assign len_zero = (len_c == '0);

	assign issue    = cmd.walk && (cnt_q != len_q);
	assign rd_addr  = base_q + cnt_q[AW-1:0];
	assign acc_done = (cnt_q == len_q) && !v_s1 && !v_s2;

	always_comb begin
		mag = '0;
		if (ok_s1) begin
			mag = rd_s1[SAMPLE_BITS-1] ? (~rd_s1 + 1'b1) : rd_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			ring_mem[wp_q] <= sample;
		end
		rd_s1 <= ring_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_cfg_q <= LEN_W'(RING_DEPTH);
			off_cfg_q <= '0;
			wp_q      <= '0;
			fill_q    <= '0;
			len_q     <= '0;
			cnt_q     <= '0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_idx == REG_LEN) begin
					len_cfg_q <= cfg_data;
				end else begin
					off_cfg_q <= cfg_data;
				end
			end
			if (cmd.push) begin
				wp_q <= wp_q + 1'b1;
				if (fill_q != LEN_W'(RING_DEPTH)) begin
					fill_q <= fill_q + 1'b1;
				end
			end
			if (cmd.load) begin
				len_q <= len_c;
				cnt_q <= '0;
			end else if (issue) begin
				cnt_q <= cnt_q + 1'b1;
			end
			v_s1   <= issue;
			v_s2   <= v_s1;
			done_q <= cmd.floor | cmd.cap_peak;
		end
	end

	always_ff @(posedge clk) begin
		ok_s1  <= {1'b0, rd_addr} < fill_q;
		mag_s2 <= mag;
		sq_s2  <= mag * mag;
		if (cmd.load) begin
			base_q <= start_c[AW-1:0];
			sum_q  <= '0;
			peak_q <= '0;
		end else if (v_s2) begin
			sum_q <= sum_q + ACC_BITS'(sq_s2);
			if (mag_s2 > peak_q) begin
				peak_q <= mag_s2;
			end
		end
		if (cmd.floor) begin
			rms_q <= DB_FLOOR;
			pk_q  <= DB_FLOOR;
		end
		if (cmd.cap_rms) begin
			rms_q <= db_res;
		end
		if (cmd.cap_peak) begin
			pk_q <= db_res;
		end
	end

	assign sum     = sum_q;
	assign len     = len_q;
	assign peak    = peak_q;
	assign done    = done_q;
	assign rms_db  = rms_q;
	assign peak_db = pk_q;

endmodule
`default_nettype wire

[rtl/core/windowed_rms_peak_meter.sv]
// Top level of the windowed RMS and peak level meter.
// How the block is used:
// Input words are offered on start with func and sample; a word is taken at a
// rising edge where start is high and busy is low. A push word (func 0) writes
// one sample into the 4096-entry ring and advances the write pointer; it never
// raises busy, so pushes may follow each other in every cycle while idle.
// A measure word (func 1) raises busy while the window is walked through the
// ring memory one entry per cycle, the sum of squares is divided by the window
// length one quotient bit per cycle, and the shared dB unit runs twice (a
// normalising shift, twenty squaring steps of a multiply and a square state
// each, then scale and round). With an empty window the result word appears
// in the next cycle.
// The result word is shown on rms_db and peak_db, marked by done for a single
// cycle; the receiver cannot stall, and busy is already low in that cycle.
// Configuration writes (cfg_we, cfg_idx, cfg_data) take effect at once and
// belong only in idle periods. Reset restores a window of 4096 samples with no
// offset and empties the ring: unwritten entries read as zero through a fill
// count, so no clearing pass is needed after reset.
`timescale 1ns / 1ps
`default_nettype none
module windowed_rms_peak_meter (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    start,
	output logic                                         busy,
	input  wire logic                                    func,
	input  wire logic signed [wrpm_pkg::SAMPLE_BITS-1:0] sample,
	input  wire logic                                    cfg_we,
	input  wire logic                                    cfg_idx,
	input  wire logic [wrpm_pkg::LEN_W-1:0]              cfg_data,
	output logic                                         done,
	output logic signed [wrpm_pkg::DB_W-1:0]             rms_db,
	output logic signed [wrpm_pkg::DB_W-1:0]             peak_db
);
	import wrpm_pkg::*;

	cmd_t                   cmd;
	status_t                st;
	logic                   len_zero, acc_done, div_done, db_done;
	logic [ACC_BITS-1:0]    sum, quot;
	logic [LEN_W-1:0]       len;
	logic [SAMPLE_BITS-1:0] peak;
	logic signed [DB_W-1:0] db_res;

	// Status from the datapath and the two arithmetic units goes back to the
	// controller as one group.
	assign st = '{len_zero: len_zero, acc_done: acc_done,
		div_done: div_done, db_done: db_done};

	wrpm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.func   (func),
		.st     (st),
		.cmd    (cmd),
		.busy   (busy)
	);

	wrpm_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sample   (sample),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.db_res   (db_res),
		.len_zero (len_zero),
		.acc_done (acc_done),
		.sum      (sum),
		.len      (len),
		.peak     (peak),
		.done     (done),
		.rms_db   (rms_db),
		.peak_db  (peak_db)
	);

	// The mean square is the floor of the sum over the window length.
	wrpm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (sum),
		.divisor  (len),
		.done     (div_done),
		.quot     (quot)
	);

	// One dB unit serves both levels, the RMS first and then the peak.
	wrpm_db u_db (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.db_start),
		.sel_rms (cmd.db_sel_rms),
		.mean    (quot),
		.peak    (peak),
		.done    (db_done),
		.res     (db_res)
	);

endmodule
`default_nettype wire

[dv/windowed_rms_peak_meter_tb.sv]
// Self-checking testbench for the windowed RMS and peak level meter.
`timescale 1ns / 1ps
module windowed_rms_peak_meter_tb;
	import wrpm_pkg::*;

	// The scoreboard keeps its own copy of the sample ring, the write pointer and both
	// registers. From these it works out the level pair that each measure word should
	// return, and it holds the pairs in order until the block delivers them.
	class level_scoreboard;
		typedef struct {
			logic signed [DB_W-1:0] rms;
			logic signed [DB_W-1:0] peak;
		} level_pair_t;

		logic signed [SAMPLE_BITS-1:0] ring [RING_DEPTH];
		logic [AW-1:0]                 wr_ptr;
		logic [LEN_W-1:0]              win_len;
		logic signed [LEN_W-1:0]       win_off;
		level_pair_t                   levels_due [$];
		int                            mismatches;
		int                            results_seen;

		function new();
			foreach (ring[i]) ring[i] = '0;
			wr_ptr       = '0;
			win_len      = 13'd4096;
			win_off      = '0;
			mismatches   = 0;
			results_seen = 0;
		endfunction

		function void set_reg(logic idx, logic [LEN_W-1:0] data);
			if (idx == REG_LEN) begin
				win_len = data;
			end else begin
				win_off = data;
			end
		endfunction

		// The log2 of x in Q.20. The mantissa is squared twenty times, and each square
		// is truncated.
		function longint log2_fix(longint unsigned x);
			int             n;
			longint unsigned y;
			longint         f;
			n = 63;
			f = 0;
			while (n > 0 && x[n] == 1'b0) n--;
			y = (n >= 30) ? (x >> (n - 30)) : (x << (30 - n));
			for (int i = 0; i < FRAC_BITS; i++) begin
				y = (y * y) >> 30;
				f = f * 2;
				if (y >= (64'd1 << 31)) begin
					y = y >> 1;
					f = f + 1;
				end
			end
			return longint'(n) * (64'sd1 << FRAC_BITS) + f;
		endfunction

		// The level in hundredths of dB. Rounding is half up, so an arithmetic shift
		// of the value plus one half gives the result. Zero reads as the floor.
		function logic signed [DB_W-1:0] to_db(longint unsigned x, int full, longint k);
			longint v;
			longint r;
			if (x == 0) return DB_FLOOR;
			v = (log2_fix(x) - longint'(full) * (64'sd1 << FRAC_BITS)) * k + (64'sd1 << 35);
			r = v >>> 36;
			if (r < -10000) r = -10000;
			if (r > 0) r = 0;
			return DB_W'(r);
		endfunction

		function void take_word(logic f, logic signed [SAMPLE_BITS-1:0] s);
			int              len, off, maxoff, centre, first;
			longint unsigned sum_sq, peak, a;
			level_pair_t     p;
			if (f == FUNC_PUSH) begin
				ring[wr_ptr] = s;
				wr_ptr       = wr_ptr + 1'b1;
				return;
			end
			len    = (win_len > RING_DEPTH) ? RING_DEPTH : int'(win_len);
			off    = int'(win_off);
			maxoff = (RING_DEPTH - len) / 2;
			if (off > maxoff) off = maxoff;
			if (off < -maxoff) off = -maxoff;
			centre = (int'(wr_ptr) + RING_DEPTH / 2) % RING_DEPTH;
			first  = (centre + 2 * RING_DEPTH - len / 2 - off) % RING_DEPTH;
			if (len == 0) begin
				p.rms  = DB_FLOOR;
				p.peak = DB_FLOOR;
			end else begin
				sum_sq = 0;
				peak   = 0;
				for (int i = 0; i < len; i++) begin
					a = (ring[(first + i) % RING_DEPTH] < 0) ?
						longint'(-longint'(ring[(first + i) % RING_DEPTH])) :
						longint'(ring[(first + i) % RING_DEPTH]);
					sum_sq += a * a;
					if (a > peak) peak = a;
				end
				p.rms  = to_db(sum_sq / longint'(len), FULL_RMS, longint'(K_POW));
				p.peak = to_db(peak, FULL_PEAK, longint'(K_AMP));
			end
			levels_due.push_back(p);
		endfunction

		function void check_levels(logic signed [DB_W-1:0] rms, logic signed [DB_W-1:0] peak);
			level_pair_t p;
			results_seen++;
			if (levels_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word: rms %0d peak %0d", rms, peak);
				return;
			end
			p = levels_due.pop_front();
			if (rms !== p.rms || peak !== p.peak) begin
				mismatches++;
				if (mismatches <= 10)
					$display("level mismatch: rms %0d (expected %0d), peak %0d (expected %0d)",
						rms, p.rms, peak, p.peak);
			end
		endfunction
	endclass

	logic                          clk;
	logic                          arst_n;
	logic                          start;
	logic                          busy;
	logic                          func;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic                          cfg_we;
	logic                          cfg_idx;
	logic [LEN_W-1:0]              cfg_data;
	logic                          done;
	logic signed [DB_W-1:0]        rms_db;
	logic signed [DB_W-1:0]        peak_db;

	level_scoreboard levels;
	int              idle_pct;
	int              pushes;
	int              measures;

	windowed_rms_peak_meter uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .func(func),
		.sample(sample), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.done(done), .rms_db(rms_db), .peak_db(peak_db)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// The run is stopped here if the block stops answering.
	initial begin
		#20_000_000;
		$display("windowed_rms_peak_meter verification failed");
		$finish;
	end

	// Results are held for exactly one cycle and cannot be stalled. They are sampled
	// on the falling edge, when every output has settled.
	always @(negedge clk) begin
		if (arst_n && done) begin
			levels.check_levels(rms_db, peak_db);
		end
	end

	// This task offers one word and returns once it is sure to be taken. Busy only changes
	// at a rising edge, so its value at the falling edge before that edge decides
	// whether the word is accepted there. The word is passed to the scoreboard at
	// that point, before the edge, so its expectation is always waiting first.
	task automatic send_word(logic f, logic signed [SAMPLE_BITS-1:0] s);
		while ($urandom_range(99) < idle_pct) begin
			@(posedge clk);
			start <= 1'b0;
		end
		@(posedge clk);
		start  <= 1'b1;
		func   <= f;
		sample <= s;
		forever begin
			@(negedge clk);
			if (!busy) break;
			@(posedge clk);
		end
		levels.take_word(f, s);
		if (f == FUNC_PUSH) pushes++; else measures++;
	endtask

	// Registers are only written while the block is idle, once every result is in.
	task automatic write_reg(logic idx, logic [LEN_W-1:0] data);
		@(posedge clk);
		start <= 1'b0;
		while (levels.levels_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		levels.set_reg(idx, data);
	endtask

	// Samples come in a mix of full scale extremes, values near zero (which
	// probe the floor) and fully random words.
	function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
		case ($urandom_range(5))
			0: return 24'sh800000;
			1: return 24'sh7FFFFF;
			2: return SAMPLE_BITS'($signed($urandom_range(64)) - 32);
			default: return SAMPLE_BITS'($urandom);
		endcase
	endfunction

	// Each phase runs with one register setting and one rate of sender idling. The
	// large windows walk every one of their entries per measurement, so their phases stay
	// short in measures just as the others do.
	task automatic run_phase(int len, int off, int pct, int words);
		write_reg(REG_LEN, LEN_W'(len));
		write_reg(REG_OFF, LEN_W'(off));
		idle_pct = pct;
		for (int i = 0; i < words; i++) begin
			if ($urandom_range(9) == 0)
				send_word(FUNC_MEAS, SAMPLE_BITS'($urandom));
			else
				send_word(FUNC_PUSH, pick_sample());
		end
	endtask

	initial begin
		levels   = new();
		arst_n   = 1'b0;
		start    = 1'b0;
		func     = FUNC_PUSH;
		sample   = '0;
		cfg_we   = 1'b0;
		cfg_idx  = REG_LEN;
		cfg_data = '0;
		idle_pct = 0;
		pushes   = 0;
		measures = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed words. The first measurement sees the ring as it is after reset,
		// which is all zeros. Then come the sample extremes under the reset window, and
		// a measure word that carries a sample, which must not be written.
		send_word(FUNC_MEAS, '0);
		send_word(FUNC_PUSH, 24'sh800000);
		send_word(FUNC_PUSH, 24'sh7FFFFF);
		send_word(FUNC_PUSH, 24'sh000001);
		send_word(FUNC_PUSH, -24'sd1);
		send_word(FUNC_PUSH, '0);
		send_word(FUNC_MEAS, 24'sh7FFFFF);
		send_word(FUNC_MEAS, '0);
		// An empty window.
		write_reg(REG_LEN, 13'd0);
		send_word(FUNC_MEAS, '0);
		// A window of one sample, panned beyond its limit on both sides. With tiny
		// levels in the ring the results fall below the floor.
		write_reg(REG_LEN, 13'd1);
		write_reg(REG_OFF, 13'd2048);
		send_word(FUNC_MEAS, '0);
		write_reg(REG_OFF, -13'sd2048);
		send_word(FUNC_MEAS, '0);
		for (int i = 0; i < 6; i++) send_word(FUNC_PUSH, 24'sd1);
		write_reg(REG_LEN, 13'd8);
		write_reg(REG_OFF, 13'd4095);
		send_word(FUNC_MEAS, '0);
		// The largest register value, which is capped at the ring depth.
		write_reg(REG_LEN, 13'd8191);
		write_reg(REG_OFF, 13'd4096);
		send_word(FUNC_MEAS, '0);

		// Random phases, running through the idling rates.
		run_phase(0,    0,     0,  230);
		run_phase(16,   2048,  68, 240);
		run_phase(100,  -2048, 37, 240);
		run_phase(4096, 37,    0,  220);
		run_phase(4095, -1,    68, 200);
		run_phase(8191, 5,     37, 200);
		run_phase(1,    -7,    68, 230);
		for (int ph = 0; ph < 3; ph++)
			run_phase($urandom_range(300, 2), $urandom_range(8191) - 4096, 37 * ph, 150);

		@(posedge clk);
		start <= 1'b0;
		while (levels.levels_due.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);

		$display("Covered %0d pushes and %0d measures, %0d result words checked,",
			pushes, measures, levels.results_seen);
		$display("across empty, single-sample, capped and clamped-offset windows.");
		if (levels.mismatches == 0 && levels.levels_due.size() == 0) begin
			$display("windowed_rms_peak_meter verification clean");
		end else begin
			$display("%0d mismatches, %0d results missing", levels.mismatches,
				levels.levels_due.size());
			$display("windowed_rms_peak_meter verification failed");
		end
		$finish;
	end
endmodule
